### hw/rtl/lrupr_pkg.sv
// Shared types and constants for the LRU page replacement block.
`default_nettype none

package lrupr_pkg;

    localparam int CFG_W   = 4;
    localparam int COUNT_W = 16;

    localparam logic [CFG_W-1:0]   FRAMES_RESET = 4'd8;
    localparam logic [COUNT_W-1:0] FAULT_MAX    = 16'hFFFF;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    typedef struct packed {
        logic hit;
        logic empty;
    } t_cell_stat;

endpackage

`default_nettype wire

### hw/rtl/lrupr_cell.sv
// One recency stack position: compare, priority link, shift from upper neighbor.
`default_nettype none

module lrupr_cell
    import lrupr_pkg::*;
#(
    parameter int PAGE_BITS = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_load,
    input  wire logic                 i_active,
    input  wire logic                 i_is_last,
    input  wire logic [PAGE_BITS-1:0] i_page,
    input  wire logic [PAGE_BITS-1:0] i_left_page,
    input  wire logic                 i_left_valid,
    input  wire logic                 i_stop,
    input  wire logic [PAGE_BITS-1:0] i_evict,
    output      logic [PAGE_BITS-1:0] o_page,
    output      logic                 o_valid,
    output      logic                 o_stop,
    output      t_cell_stat           o_stat,
    output      logic [PAGE_BITS-1:0] o_evict
);

    logic [PAGE_BITS-1:0] r_page;
    logic                 r_valid;

    always_comb begin
        o_stat.hit   = !i_stop && i_active && r_valid && (r_page == i_page);
        o_stat.empty = !i_stop && i_active && !r_valid;
        o_stop       = i_stop || o_stat.hit || o_stat.empty;
        // pass the bottom active page down the chain as eviction candidate
        o_evict      = (i_active && i_is_last) ? r_page : i_evict;
        o_page       = r_page;
        o_valid      = r_valid;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            if (!i_active) begin
                r_valid <= 1'b0;
            end else if (!i_stop) begin
                r_valid <= i_left_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_active && !i_stop) begin
            r_page <= i_left_page;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/lru_page_replacement.sv
// Each accepted item's result is registered in the output register.
// Throughput: one item per cycle while the consumer does not stall; the lookup ripples
// once through the chain of MAX_FRAMES position cells, which sets the cycle time.
// Reset: all frames empty, fault count zero, r_frames back to 8,
// output register empty.
`default_nettype none

module lru_page_replacement
    import lrupr_pkg::*;
#(
    parameter int MAX_FRAMES = 8,
    parameter int PAGE_BITS  = 10
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic                 i_valid,
    output      logic                 o_ready,
    input  wire logic [PAGE_BITS-1:0] i_page_number,
    output      logic                 o_valid,
    input  wire logic                 i_ready,
    output      logic [1:0]           o_outcome,
    output      logic [PAGE_BITS-1:0] o_evicted_page,
    output      logic [COUNT_W-1:0]   o_fault_total
);

    localparam int FW = $clog2(MAX_FRAMES + 1);

    logic [CFG_W-1:0]     r_frames;
    logic [COUNT_W-1:0]   r_faults;
    logic [COUNT_W-1:0]   n_faults;
    logic                 r_out_valid;
    logic [1:0]           r_outcome;
    logic [1:0]           n_outcome;
    logic [PAGE_BITS-1:0] r_evicted;
    logic [PAGE_BITS-1:0] n_evicted;

    logic                 w_accept;
    logic [FW-1:0]        w_count;

    logic [PAGE_BITS-1:0] w_page   [MAX_FRAMES];
    logic                 w_valid  [MAX_FRAMES];
    logic [PAGE_BITS-1:0] w_evict  [MAX_FRAMES+1];
    logic                 w_stop   [MAX_FRAMES+1];
    logic [MAX_FRAMES-1:0] w_hit_vec;
    logic [MAX_FRAMES-1:0] w_empty_vec;

    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    // clamp the configured frame count into 1..MAX_FRAMES
    always_comb begin
        if (r_frames == '0) begin
            w_count = FW'(1);
        end else if (32'(r_frames) > MAX_FRAMES) begin
            w_count = FW'(MAX_FRAMES);
        end else begin
            w_count = FW'(r_frames);
        end
    end

    assign w_stop[0]  = 1'b0;
    assign w_evict[0] = '0;

    for (genvar g = 0; g < MAX_FRAMES; g++) begin : g_cell
        logic [PAGE_BITS-1:0] w_left_page;
        logic                 w_left_valid;
        t_cell_stat           w_stat;

        if (g == 0) begin : g_head
            assign w_left_page  = i_page_number;
            assign w_left_valid = 1'b1;
        end else begin : g_body
            assign w_left_page  = w_page[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        lrupr_cell #(
            .PAGE_BITS (PAGE_BITS)
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_load       (w_accept),
            .i_active     (32'(w_count) > g),
            .i_is_last    (32'(w_count) == g + 1),
            .i_page       (i_page_number),
            .i_left_page  (w_left_page),
            .i_left_valid (w_left_valid),
            .i_stop       (w_stop[g]),
            .i_evict      (w_evict[g]),
            .o_page       (w_page[g]),
            .o_valid      (w_valid[g]),
            .o_stop       (w_stop[g+1]),
            .o_stat       (w_stat),
            .o_evict      (w_evict[g+1])
        );

        assign w_hit_vec[g]   = w_stat.hit;
        assign w_empty_vec[g] = w_stat.empty;
    end

    always_comb begin
        n_evicted = '0;
        if (|w_hit_vec) begin
            n_outcome = OUT_HIT;
        end else if (|w_empty_vec) begin
            n_outcome = OUT_FILL;
        end else begin
            n_outcome = OUT_EVICT;
            n_evicted = w_evict[MAX_FRAMES];
        end
        n_faults = r_faults;
        if (n_outcome != OUT_HIT && r_faults != FAULT_MAX) begin
            n_faults = r_faults + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frames    <= FRAMES_RESET;
            r_faults    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_frames <= i_cfg_data;
            end
            if (w_accept) begin
                r_faults <= n_faults;
            end
            r_out_valid <= w_accept || (r_out_valid && !i_ready);
        end
    end

    // hold the result while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_outcome <= n_outcome;
            r_evicted <= n_evicted;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_outcome      = r_outcome;
    assign o_evicted_page = r_evicted;
    assign o_fault_total  = r_faults;

`ifndef NO_ASSERTIONS
    a_one_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({w_hit_vec, w_empty_vec}))
        else $error("more than one stack position claimed the item");

    a_head_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> w_valid[0])
        else $error("most recent position empty after an item");

    a_fault_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_faults == $past(r_faults) || r_faults == $past(r_faults) + 16'd1))
        else $error("fault count moved by more than one");
`endif

endmodule

`default_nettype wire

### test/tb_top.sv
// Self-checking testbench for lru_page_replacement: directed table, random phases, one-frame tail.
module tb_top
    import lrupr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAMES = 8;
    localparam int PAGE_W = 10;
    localparam int DIR_N  = 24;
    localparam int POOL_N = 12;

    // receiver stall patterns
    localparam logic [1:0] RX_OPEN = 2'd0;
    localparam logic [1:0] RX_HALF = 2'd1;
    localparam logic [1:0] RX_SLOW = 2'd2;

    typedef struct packed {
        logic [1:0]         outcome;
        logic [PAGE_W-1:0]  evicted;
        logic [COUNT_W-1:0] total;
    } t_lru_result;

    typedef struct {
        bit                set_cfg;
        logic [CFG_W-1:0]  cfg;
        logic [PAGE_W-1:0] page;
        bit                known;
        t_lru_result       res;
    } t_dir_row;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]   i_cfg_data    = FRAMES_RESET;
    logic               i_valid       = 1'b0;
    logic [PAGE_W-1:0]  i_page_number = '0;
    logic               i_ready       = 1'b0;
    logic               o_ready;
    logic               o_valid;
    logic [1:0]         o_outcome;
    logic [PAGE_W-1:0]  o_evicted_page;
    logic [COUNT_W-1:0] o_fault_total;

    lru_page_replacement #(
        .MAX_FRAMES (FRAMES),
        .PAGE_BITS  (PAGE_W)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_page_number  (i_page_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_outcome      (o_outcome),
        .o_evicted_page (o_evicted_page),
        .o_fault_total  (o_fault_total)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Predicted block state
    logic [PAGE_W-1:0]  frame_page [FRAMES];
    logic               frame_used [FRAMES];
    logic [COUNT_W-1:0] fault_ct;
    logic [CFG_W-1:0]   frames_cfg;

    t_lru_result pending_results [$];
    t_lru_result head;
    t_lru_result predicted;
    int unsigned mismatch_ct = 0;

    // Typed expectation carried alongside the item on the bus
    bit          row_on  = 1'b0;
    t_lru_result row_res = '0;

    function automatic void lru_clear();
        for (int i = 0; i < FRAMES; i++) begin
            frame_page[i] = '0;
            frame_used[i] = 1'b0;
        end
        fault_ct   = '0;
        frames_cfg = FRAMES_RESET;
    endfunction

    function automatic t_lru_result lru_lookup(input logic [PAGE_W-1:0] pg);
        t_lru_result r;
        int n;
        int slot;
        n = (frames_cfg == 0) ? 1 : (int'(frames_cfg) > FRAMES) ? FRAMES : int'(frames_cfg);
        r.outcome = OUT_EVICT;
        r.evicted = '0;
        // drop frames beyond the current count without reporting them
        for (int i = n; i < FRAMES; i++)
            frame_used[i] = 1'b0;
        slot = n - 1;
        // scan from the bottom so the topmost hit or empty frame wins
        for (int i = n - 1; i >= 0; i--) begin
            if (frame_used[i] && frame_page[i] == pg) begin
                r.outcome = OUT_HIT;
                slot = i;
            end else if (!frame_used[i]) begin
                r.outcome = OUT_FILL;
                slot = i;
            end
        end
        if (r.outcome == OUT_EVICT)
            r.evicted = frame_page[slot];
        for (int i = slot; i > 0; i--) begin
            frame_page[i] = frame_page[i-1];
            frame_used[i] = frame_used[i-1];
        end
        frame_page[0] = pg;
        frame_used[0] = 1'b1;
        if (r.outcome != OUT_HIT && fault_ct != FAULT_MAX)
            fault_ct++;
        r.total = fault_ct;
        return r;
    endfunction

    task automatic flag(input string what, input int unsigned want, input int unsigned got);
        mismatch_ct++;
        $display("%0t %s mismatch: expected %0d, got %0d", $time, what, want, got);
    endtask

    // Check results first, then apply config, then predict the accepted item
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            lru_clear();
            pending_results.delete();
        end else begin
            if (o_valid && i_ready) begin
                if (pending_results.size() == 0) begin
                    mismatch_ct++;
                    $display("%0t unexpected item: expected none, got %0d %0d %0d",
                             $time, o_outcome, o_evicted_page, o_fault_total);
                end else begin
                    head = pending_results.pop_front();
                    if (o_outcome !== head.outcome)
                        flag("outcome", head.outcome, o_outcome);
                    if (o_evicted_page !== head.evicted)
                        flag("evicted_page", head.evicted, o_evicted_page);
                    if (o_fault_total !== head.total)
                        flag("fault_total", head.total, o_fault_total);
                end
            end
            if (i_cfg_we)
                frames_cfg = i_cfg_data;
            if (i_valid && o_ready) begin
                predicted = lru_lookup(i_page_number);
                pending_results.push_back(row_on ? row_res : predicted);
            end
        end
    end

    // Receiver: switch between open, half and slow stall patterns
    int unsigned stall_ct   = 0;
    logic [1:0]  stall_mode = RX_OPEN;

    always @(posedge i_clk) begin
        if (stall_ct == 0) begin
            stall_mode <= 2'($urandom_range(0, 2));
            stall_ct   <= $urandom_range(16, 96);
        end else begin
            stall_ct <= stall_ct - 1;
        end
        case (stall_mode)
            RX_OPEN: i_ready <= 1'b1;
            RX_HALF: i_ready <= 1'($urandom_range(0, 1));
            default: i_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Present one item and hold it until accepted; valid stays high on return
    task automatic push_page(input logic [PAGE_W-1:0] pg, input bit known,
                             input t_lru_result typed);
        i_valid       <= 1'b1;
        i_page_number <= pg;
        row_on        <= known;
        row_res       <= typed;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_frames(input logic [CFG_W-1:0] v);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    initial begin
        t_dir_row          dir_rows [DIR_N];
        logic [CFG_W-1:0]  cfg_seq [6];
        logic [PAGE_W-1:0] pool [POOL_N];
        logic [PAGE_W-1:0] pg;
        logic [PAGE_W-1:0] last_pg;
        int                burst_left;
        int                sel;

        dir_rows = '{
            '{1'b0, 4'd0,  10'd0,    1'b1, '{OUT_FILL,  10'd0,    16'd1}},
            '{1'b0, 4'd0,  10'd0,    1'b1, '{OUT_HIT,   10'd0,    16'd1}},
            '{1'b0, 4'd0,  10'd1023, 1'b1, '{OUT_FILL,  10'd0,    16'd2}},
            '{1'b0, 4'd0,  10'd0,    1'b1, '{OUT_HIT,   10'd0,    16'd2}},
            '{1'b0, 4'd0,  10'd341,  1'b1, '{OUT_FILL,  10'd0,    16'd3}},
            '{1'b1, 4'd1,  10'd682,  1'b1, '{OUT_EVICT, 10'd341,  16'd4}},
            '{1'b0, 4'd0,  10'd682,  1'b1, '{OUT_HIT,   10'd0,    16'd4}},
            '{1'b0, 4'd0,  10'd1023, 1'b1, '{OUT_EVICT, 10'd682,  16'd5}},
            '{1'b1, 4'd0,  10'd5,    1'b1, '{OUT_EVICT, 10'd1023, 16'd6}},
            '{1'b1, 4'd15, 10'd6,    1'b1, '{OUT_FILL,  10'd0,    16'd7}},
            '{1'b0, 4'd0,  10'd7,    1'b1, '{OUT_FILL,  10'd0,    16'd8}},
            '{1'b0, 4'd0,  10'd8,    1'b1, '{OUT_FILL,  10'd0,    16'd9}},
            '{1'b0, 4'd0,  10'd9,    1'b1, '{OUT_FILL,  10'd0,    16'd10}},
            '{1'b0, 4'd0,  10'd10,   1'b1, '{OUT_FILL,  10'd0,    16'd11}},
            '{1'b0, 4'd0,  10'd11,   1'b1, '{OUT_FILL,  10'd0,    16'd12}},
            '{1'b0, 4'd0,  10'd12,   1'b1, '{OUT_FILL,  10'd0,    16'd13}},
            '{1'b0, 4'd0,  10'd5,    1'b1, '{OUT_HIT,   10'd0,    16'd13}},
            '{1'b0, 4'd0,  10'd1,    1'b1, '{OUT_EVICT, 10'd6,    16'd14}},
            '{1'b1, 4'd3,  10'd8,    1'b1, '{OUT_EVICT, 10'd12,   16'd15}},
            '{1'b1, 4'd9,  10'd12,   1'b1, '{OUT_FILL,  10'd0,    16'd16}},
            '{1'b0, 4'd0,  10'd1,    1'b1, '{OUT_HIT,   10'd0,    16'd16}},
            '{1'b1, 4'd8,  10'd512,  1'b0, '{OUT_HIT,   10'd0,    16'd0}},
            '{1'b0, 4'd0,  10'd8,    1'b0, '{OUT_HIT,   10'd0,    16'd0}},
            '{1'b0, 4'd0,  10'd1,    1'b0, '{OUT_HIT,   10'd0,    16'd0}}
        };
        cfg_seq    = '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd6};
        burst_left = 0;
        last_pg    = '0;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            if (dir_rows[r].set_cfg)
                write_frames(dir_rows[r].cfg);
            push_page(dir_rows[r].page, dir_rows[r].known, dir_rows[r].res);
        end

        // Random phases: mostly a small working set so hits and evictions mix
        for (int ph = 0; ph < 8; ph++) begin
            write_frames(ph < 6 ? cfg_seq[ph] : 4'($urandom_range(0, 15)));
            for (int i = 0; i < POOL_N; i++)
                pool[i] = 10'($urandom_range(0, 1023));
            for (int k = 0; k < 80; k++) begin
                if (burst_left == 0) begin
                    i_valid <= 1'b0;
                    repeat ($urandom_range(1, 8)) @(posedge i_clk);
                    burst_left = $urandom_range(1, 40);
                end
                burst_left--;
                sel = $urandom_range(0, 9);
                if (sel < 6)
                    pg = pool[$urandom_range(0, POOL_N - 1)];
                else if (sel < 8)
                    pg = last_pg;
                else
                    pg = 10'($urandom_range(0, 1023));
                push_page(pg, 1'b0, '0);
                last_pg = pg;
                if (ph == 2 && k == 40)
                    drain_results();
            end
        end

        // One frame: repeats hit, anything else evicts the single page
        write_frames(4'd1);
        for (int k = 0; k < 40; k++) begin
            pg = ($urandom_range(0, 1) == 0) ? last_pg : 10'($urandom_range(0, 1023));
            push_page(pg, 1'b0, '0);
            last_pg = pg;
        end

        drain_results();
        repeat (4) @(posedge i_clk);
        if (mismatch_ct == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

endmodule

### files.f
hw/rtl/lrupr_pkg.sv
hw/rtl/lrupr_cell.sv
hw/rtl/lru_page_replacement.sv
test/tb_top.sv
